[rtl/cpb_pkg.sv]
// Package for the coverage pixel blend block: shared constants, the sideband
// type that travels beside the lanes, and the two byte conversion tables.
// No dependencies.
package cpb_pkg;

    localparam int unsigned FULL_COVER = 255;

    localparam logic [7:0] COV_NONE = 8'h00;
    localparam logic [7:0] COV_FULL = 8'hFF;

    // floor(x / 255) for x <= 65025 as (x * RECIP_255) >> RECIP_SHIFT.
    localparam logic [16:0] RECIP_255   = 17'd32897;
    localparam int unsigned RECIP_SHIFT = 23;

    typedef logic [7:0] byte_rom_t [256];

    // Per-pixel information that bypasses the channel lanes.
    typedef struct packed {
        logic        cov_zero;
        logic        cov_full;
        logic [31:0] fg_word;
        logic [31:0] bg_word;
    } side_t;

    // Result of the merge stage.
    typedef struct packed {
        logic [31:0] pixel;
        logic        write_en;
    } merge_t;

    function automatic logic [7:0] gam_entry(input int unsigned v);
        int unsigned x;
        int unsigned res;
        int unsigned bit_v;
        x     = 1020 * v;
        res   = 0;
        bit_v = 32'h4000_0000;
        while (bit_v > x)
        begin
            bit_v = bit_v >> 2;
        end
        while (bit_v != 0)
        begin
            if (x >= res + bit_v)
            begin
                x   = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return 8'((res + 1) >> 1);
    endfunction

    function automatic byte_rom_t build_lin();
        byte_rom_t rom;
        for (int i = 0; i < 256; i++)
        begin
            rom[i] = 8'((i * i) / FULL_COVER);
        end
        return rom;
    endfunction

    function automatic byte_rom_t build_gam();
        byte_rom_t rom;
        for (int i = 0; i < 256; i++)
        begin
            rom[i] = gam_entry(i);
        end
        return rom;
    endfunction

    // Byte to linear light, floor(c*c/255).
    localparam byte_rom_t LIN_ROM = build_lin();
    // Linear light back to byte, rounded square root of 255*v.
    localparam byte_rom_t GAM_ROM = build_gam();

endpackage

[rtl/cpb_in_if.sv]
// Input channel of the coverage pixel blend block: one pixel request.
// Depends on nothing.
interface cpb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  coverage;
    logic [31:0] fg_color;
    logic [31:0] bg_pixel;
    logic        gamma_mode;

    modport source (output valid, coverage, fg_color, bg_pixel, gamma_mode, input ready);
    modport sink   (input valid, coverage, fg_color, bg_pixel, gamma_mode, output ready);
endinterface

[rtl/cpb_out_if.sv]
// Output channel of the coverage pixel blend block: one composited pixel.
// Depends on nothing.
interface cpb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        write_enable;

    modport source (output valid, pixel_out, write_enable, input ready);
    modport sink   (input valid, pixel_out, write_enable, output ready);
endinterface

[rtl/cpb_lane.sv]
// One color channel lane: linearize, weighted sum, divide by 255, map back.
// Depends on cpb_pkg.
module cpb_lane
    import cpb_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] cov,
    input  logic [7:0] fg_ch,
    input  logic [7:0] bg_ch,
    input  logic       gamma,
    output logic [7:0] ch_out
);

    logic [7:0]  op_f_reg, op_f_next;
    logic [7:0]  op_b_reg, op_b_next;
    logic [7:0]  cov_reg;
    logic        gam1_reg, gam2_reg, gam3_reg;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  q_reg, q_next;
    logic [7:0]  inv_cov;
    logic [32:0] prod;

    // Stage one: optional conversion to linear light.
    assign op_f_next = gamma ? LIN_ROM[fg_ch] : fg_ch;
    assign op_b_next = gamma ? LIN_ROM[bg_ch] : bg_ch;

    // Stage two: weighted sum, at most 255*255.
    assign inv_cov  = COV_FULL - cov_reg;
    assign sum_next = ({8'd0, cov_reg} * {8'd0, op_f_reg})
                    + ({8'd0, inv_cov} * {8'd0, op_b_reg});

    // Stage three: divide by 255 through a reciprocal multiply.
    assign prod   = {17'd0, sum_reg} * {16'd0, RECIP_255};
    assign q_next = prod[RECIP_SHIFT +: 8];

    assign ch_out = gam3_reg ? GAM_ROM[q_reg] : q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_f_reg <= op_f_next;
            op_b_reg <= op_b_next;
            cov_reg  <= cov;
            gam1_reg <= gamma;
            sum_reg  <= sum_next;
            gam2_reg <= gam1_reg;
            q_reg    <= q_next;
            gam3_reg <= gam2_reg;
        end
    end

endmodule

[rtl/cpb_merge.sv]
// Merge stage: combines the three lane results with the coverage special cases.
// Depends on cpb_pkg.
module cpb_merge
    import cpb_pkg::*;
(
    input  side_t      side,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output merge_t     result
);

    always_comb
    begin
        if (side.cov_zero)
        begin
            result.pixel    = side.bg_word;
            result.write_en = 1'b0;
        end
        else if (side.cov_full)
        begin
            result.pixel    = side.fg_word;
            result.write_en = 1'b1;
        end
        else
        begin
            result.pixel    = {8'd0, red, green, blue};
            result.write_en = 1'b1;
        end
    end

endmodule

[rtl/coverage_pixel_blend_unit.sv]
// Top level of the coverage pixel blend block: three channel lanes, the merge
// stage and the output register. Depends on cpb_pkg, cpb_in_if, cpb_out_if,
// cpb_lane and cpb_merge.

// The block takes one pixel request per clock and returns one composited pixel
// for each request, in order. A request moves through the three register stages
// of each channel lane (table lookup, weighted sum, reciprocal divide) and then
// through the output register, which drives the output channel directly. The
// whole pipeline moves together: it advances whenever the output register is
// empty or being taken, so a stall on the output side holds every stage and
// drops input ready in the same cycle. There is no state between pixels and no
// configuration.
module coverage_pixel_blend_unit
    import cpb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    cpb_in_if.sink           pix_in,
    cpb_out_if.source        pix_out
);

    logic   adv;
    logic   v1_reg, v2_reg, v3_reg;
    logic   out_vld_reg;
    side_t  side_next;
    side_t  side1_reg, side2_reg, side3_reg;
    logic [7:0] red_ch, green_ch, blue_ch;
    merge_t merged;
    merge_t out_reg;

    // The pipeline advances when the output register is free or being drained.
    assign adv          = !out_vld_reg || pix_out.ready;
    assign pix_in.ready = adv;

    assign side_next.cov_zero = (pix_in.coverage == COV_NONE);
    assign side_next.cov_full = (pix_in.coverage == COV_FULL);
    assign side_next.fg_word  = pix_in.fg_color;
    assign side_next.bg_word  = pix_in.bg_pixel;

    // Red, green and blue each get a lane of their own.
    cpb_lane u_lane_red (
        .clk    (clk),
        .en     (adv),
        .cov    (pix_in.coverage),
        .fg_ch  (pix_in.fg_color[23:16]),
        .bg_ch  (pix_in.bg_pixel[23:16]),
        .gamma  (pix_in.gamma_mode),
        .ch_out (red_ch)
    );

    cpb_lane u_lane_green (
        .clk    (clk),
        .en     (adv),
        .cov    (pix_in.coverage),
        .fg_ch  (pix_in.fg_color[15:8]),
        .bg_ch  (pix_in.bg_pixel[15:8]),
        .gamma  (pix_in.gamma_mode),
        .ch_out (green_ch)
    );

    cpb_lane u_lane_blue (
        .clk    (clk),
        .en     (adv),
        .cov    (pix_in.coverage),
        .fg_ch  (pix_in.fg_color[7:0]),
        .bg_ch  (pix_in.bg_pixel[7:0]),
        .gamma  (pix_in.gamma_mode),
        .ch_out (blue_ch)
    );

    cpb_merge u_merge (
        .side   (side3_reg),
        .red    (red_ch),
        .green  (green_ch),
        .blue   (blue_ch),
        .result (merged)
    );

    // Valid bits of the three lane stages and of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= pix_in.valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            out_vld_reg <= v3_reg;
        end
    end

    // Sideband and output payload move in step with the lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            out_reg   <= merged;
        end
    end

    assign pix_out.valid        = out_vld_reg;
    assign pix_out.pixel_out    = out_reg.pixel;
    assign pix_out.write_enable = out_reg.write_en;

    // An accepted request always occupies the first lane stage next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.valid && pix_in.ready |=> v1_reg)
        else $error("accepted request did not enter the lanes");

    // A request leaving the last lane stage always reaches the output.
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v3_reg |=> out_vld_reg)
        else $error("request lost between lanes and output");

    // Zero coverage passes the background through with no write.
    a_zero_cov: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v3_reg && side3_reg.cov_zero |=>
            !out_reg.write_en && (out_reg.pixel == $past(side3_reg.bg_word)))
        else $error("zero coverage result is wrong");

    // Partial coverage writes with the top byte cleared.
    a_partial_cov: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v3_reg && !side3_reg.cov_zero && !side3_reg.cov_full |=>
            out_reg.write_en && (out_reg.pixel[31:24] == 8'd0))
        else $error("partial coverage result is wrong");

endmodule
